@@ hw/rtl/ata_seq_pkg.sv @@
// ----------------------------------------------------------------------------
// ata_seq_pkg
// Shared types and constants of the ATA PIO LBA28 sector sequencer: item
// codes, task-file offsets, command and status bytes, and the job descriptor
// that the front end passes to the back end.
// ----------------------------------------------------------------------------
package ata_seq_pkg;

    // Sector size in 16-bit words and the width of the word counter
    localparam int WORDS_PER_SECTOR = 256;
    localparam int WC_W             = $clog2(WORDS_PER_SECTOR + 1);

    // Job queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input operation codes
    localparam logic [1:0] OP_START_READ  = 2'd0;
    localparam logic [1:0] OP_START_WRITE = 2'd1;
    localparam logic [1:0] OP_BUS_REPLY   = 2'd2;
    localparam logic [1:0] OP_HOST_WORD   = 2'd3;

    // Result action codes
    localparam logic [1:0] ACT_BUS_READ  = 2'd0;
    localparam logic [1:0] ACT_BUS_WRITE = 2'd1;
    localparam logic [1:0] ACT_TO_HOST   = 2'd2;
    localparam logic [1:0] ACT_DONE      = 2'd3;

    // Task-file register offsets
    localparam logic [2:0] PORT_DATA    = 3'd0;
    localparam logic [2:0] PORT_COUNT   = 3'd2;
    localparam logic [2:0] PORT_LBA_LO  = 3'd3;
    localparam logic [2:0] PORT_LBA_MID = 3'd4;
    localparam logic [2:0] PORT_LBA_HI  = 3'd5;
    localparam logic [2:0] PORT_DEVICE  = 3'd6;
    localparam logic [2:0] PORT_CMD     = 3'd7;

    // Status bits
    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    // Commands and fixed bytes
    localparam logic [7:0] CMD_READ    = 8'h20;
    localparam logic [7:0] CMD_WRITE   = 8'h30;
    localparam logic [7:0] CMD_FLUSH   = 8'hE7;
    localparam logic [7:0] DEV_LBA     = 8'hE0;
    localparam logic [7:0] SECTOR_ONE  = 8'h01;

    // Work handed from front to back
    typedef enum logic [2:0] {
        JOB_POLL,       // one status read
        JOB_SETUP,      // device, count, LBA bytes, command, status read
        JOB_RD_FIRST,   // first data read
        JOB_RD_WORD,    // word to host, then next data or status read
        JOB_WR_WORD,    // data write, on the last word flush and status read
        JOB_DONE        // completion with ok flag
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [27:0] arg;   // LBA for setup, word for data jobs
        logic        flag;  // write for setup, last word for data, ok for done
    } job_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  port;
        logic [15:0] data;
        logic        ok;
        logic        last;
    } result_t;

endpackage

@@ hw/rtl/ata_pio_sector_sequencer.sv @@
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer
// Host-side sequencer for one-sector ATA PIO LBA28 transfers: issues the
// task-file reads and writes, polls status and moves the sector words.
//
//   Channel   Handshake        Payload
//   input     push / full      operation, lba, value
//   result    empty / pop      action, port, data, ok, last
//
// One input transaction is taken per cycle while the job queue has room.
// The back end drains one result per cycle while its output is empty or
// popped; an item causes up to seven results, the most being a setup step.
// The four-entry job queue sets how far the input side runs ahead.
// Reset clears phase, counters, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
module ata_pio_sector_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [27:0] lba,
    input  logic [15:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  action,
    output logic [2:0]  port,
    output logic [15:0] data,
    output logic        ok,
    output logic        last
);

    logic                  accept;
    logic                  job_in_valid;
    ata_seq_pkg::job_t     job_in;
    ata_seq_pkg::job_t     job_head;
    logic                  q_nonempty;
    logic                  q_pop;
    logic                  q_full;
    logic                  out_valid;
    ata_seq_pkg::result_t  out_res;

    // hold input while queue is full, so every accepted item has room for its job
    assign full   = q_full;
    assign accept = push && !q_full;

    ata_seq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .lba       (lba),
        .value     (value),
        .job_valid (job_in_valid),
        .job       (job_in)
    );

    ata_seq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept && job_in_valid),
        .push_job (job_in),
        .pop      (q_pop),
        .head     (job_head),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    ata_seq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_nonempty),
        .job       (job_head),
        .job_pop   (q_pop),
        .out_pop   (pop),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign empty  = !out_valid;
    assign action = out_res.action;
    assign port   = out_res.port;
    assign data   = out_res.data;
    assign ok     = out_res.ok;
    assign last   = out_res.last;

endmodule

@@ hw/rtl/ata_seq_front.sv @@
// ----------------------------------------------------------------------------
// ata_seq_front
// Phase tracker: takes input transactions, advances the transfer phase and
// turns each item that fits the phase into at most one job for the back end.
// ----------------------------------------------------------------------------
module ata_seq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         operation,
    input  logic [27:0]        lba,
    input  logic [15:0]        value,
    output logic               job_valid,
    output ata_seq_pkg::job_t  job
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BSY1,
        PH_DRQ,
        PH_RDATA,
        PH_WDATA,
        PH_BSY2,
        PH_FINAL
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic                         is_write_reg, is_write_next;
    logic [27:0]                  addr_reg, addr_next;
    logic [ata_seq_pkg::WC_W-1:0] wc_reg, wc_next;
    logic [ata_seq_pkg::WC_W-1:0] wc_inc;
    logic                         wc_final;
    logic [7:0]                   st;
    logic                         is_reply;

    assign st       = value[7:0];
    assign is_reply = (operation == ata_seq_pkg::OP_BUS_REPLY);
    assign wc_inc   = wc_reg + ata_seq_pkg::WC_W'(1);
    assign wc_final = (wc_inc >= ata_seq_pkg::WC_W'(ata_seq_pkg::WORDS_PER_SECTOR));

    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        addr_next     = addr_reg;
        wc_next       = wc_reg;
        job_valid     = 1'b0;
        job.kind      = ata_seq_pkg::JOB_POLL;
        job.arg       = {12'd0, value};
        job.flag      = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (operation == ata_seq_pkg::OP_START_READ ||
                        operation == ata_seq_pkg::OP_START_WRITE)
                    begin
                        is_write_next = (operation == ata_seq_pkg::OP_START_WRITE);
                        addr_next     = lba;
                        wc_next       = '0;
                        phase_next    = PH_BSY1;
                        job_valid     = 1'b1;
                    end
                end
                PH_BSY1:
                begin
                    if (is_reply)
                    begin
                        job_valid = 1'b1;
                        if (!st[ata_seq_pkg::ST_BSY_BIT])
                        begin
                            job.kind   = ata_seq_pkg::JOB_SETUP;
                            job.arg    = addr_reg;
                            job.flag   = is_write_reg;
                            phase_next = PH_DRQ;
                        end
                    end
                end
                PH_DRQ:
                begin
                    if (is_reply)
                    begin
                        if (!st[ata_seq_pkg::ST_DRQ_BIT])
                        begin
                            job_valid = 1'b1;
                        end
                        else
                        begin
                            wc_next = '0;
                            if (is_write_reg)
                            begin
                                // wait for host words, nothing to emit
                                phase_next = PH_WDATA;
                            end
                            else
                            begin
                                job_valid  = 1'b1;
                                job.kind   = ata_seq_pkg::JOB_RD_FIRST;
                                phase_next = PH_RDATA;
                            end
                        end
                    end
                end
                PH_RDATA:
                begin
                    if (is_reply)
                    begin
                        job_valid = 1'b1;
                        job.kind  = ata_seq_pkg::JOB_RD_WORD;
                        job.flag  = wc_final;
                        wc_next   = wc_inc;
                        if (wc_final)
                        begin
                            phase_next = PH_FINAL;
                        end
                    end
                end
                PH_WDATA:
                begin
                    if (operation == ata_seq_pkg::OP_HOST_WORD)
                    begin
                        job_valid = 1'b1;
                        job.kind  = ata_seq_pkg::JOB_WR_WORD;
                        job.flag  = wc_final;
                        wc_next   = wc_inc;
                        if (wc_final)
                        begin
                            phase_next = PH_BSY2;
                        end
                    end
                end
                PH_BSY2:
                begin
                    if (is_reply)
                    begin
                        job_valid = 1'b1;
                        if (!st[ata_seq_pkg::ST_BSY_BIT])
                        begin
                            phase_next = PH_FINAL;
                        end
                    end
                end
                PH_FINAL:
                begin
                    if (is_reply)
                    begin
                        job_valid  = 1'b1;
                        job.kind   = ata_seq_pkg::JOB_DONE;
                        job.flag   = !st[ata_seq_pkg::ST_ERR_BIT];
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_write_reg <= 1'b0;
            addr_reg     <= '0;
            wc_reg       <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            is_write_reg <= is_write_next;
            addr_reg     <= addr_next;
            wc_reg       <= wc_next;
        end
    end

`ifndef ASSERT_OFF
    a_wdata_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WDATA |-> is_write_reg)
        else $error("write data phase on a read transfer");

    a_rdata_is_read: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RDATA |-> !is_write_reg)
        else $error("read data phase on a write transfer");

    a_wc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RDATA || phase_reg == PH_WDATA)
        |-> wc_reg < ata_seq_pkg::WC_W'(ata_seq_pkg::WORDS_PER_SECTOR))
        else $error("word count past sector size in a data phase");

    a_start_to_bsy1: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE && !operation[1] |=> phase_reg == PH_BSY1)
        else $error("start request did not begin busy polling");
`endif

endmodule

@@ hw/rtl/ata_seq_queue.sv @@
// ----------------------------------------------------------------------------
// ata_seq_queue
// Small job queue between the phase tracker and the result expander.
// ----------------------------------------------------------------------------
module ata_seq_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ata_seq_pkg::job_t  push_job,
    input  logic               pop,
    output ata_seq_pkg::job_t  head,
    output logic               full,
    output logic               nonempty
);

    ata_seq_pkg::job_t                mem [ata_seq_pkg::QDEPTH];
    logic [ata_seq_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ata_seq_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ata_seq_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                             do_push, do_pop;

    assign full     = (count_reg == ata_seq_pkg::QCNT_W'(ata_seq_pkg::QDEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + ata_seq_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + ata_seq_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + ata_seq_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - ata_seq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/ata_seq_back.sv @@
// ----------------------------------------------------------------------------
// ata_seq_back
// Result expander: walks the queue head job into an output register, one
// result per cycle while it is free or popped; the last one retires the job.
// ----------------------------------------------------------------------------
module ata_seq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  ata_seq_pkg::job_t    job,
    output logic                 job_pop,
    input  logic                 out_pop,
    output logic                 out_valid,
    output ata_seq_pkg::result_t out_res
);

    logic [2:0]            step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    ata_seq_pkg::result_t  out_res_reg, out_res_next;
    ata_seq_pkg::result_t  res;
    logic                  advance;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign advance   = job_valid && (!out_valid_reg || out_pop);
    assign job_pop   = advance && res.last;

    // Decode (job, step) into one result
    always_comb
    begin
        res.action = ata_seq_pkg::ACT_BUS_READ;
        res.port   = ata_seq_pkg::PORT_CMD;
        res.data   = '0;
        res.ok     = 1'b0;
        res.last   = 1'b1;
        unique case (job.kind)
            ata_seq_pkg::JOB_POLL:
            begin
            end
            ata_seq_pkg::JOB_SETUP:
            begin
                res.action = ata_seq_pkg::ACT_BUS_WRITE;
                res.last   = 1'b0;
                case (step_reg)
                    3'd0:
                    begin
                        res.port = ata_seq_pkg::PORT_DEVICE;
                        res.data = {8'd0, ata_seq_pkg::DEV_LBA | {4'd0, job.arg[27:24]}};
                    end
                    3'd1:
                    begin
                        res.port = ata_seq_pkg::PORT_COUNT;
                        res.data = {8'd0, ata_seq_pkg::SECTOR_ONE};
                    end
                    3'd2:
                    begin
                        res.port = ata_seq_pkg::PORT_LBA_LO;
                        res.data = {8'd0, job.arg[7:0]};
                    end
                    3'd3:
                    begin
                        res.port = ata_seq_pkg::PORT_LBA_MID;
                        res.data = {8'd0, job.arg[15:8]};
                    end
                    3'd4:
                    begin
                        res.port = ata_seq_pkg::PORT_LBA_HI;
                        res.data = {8'd0, job.arg[23:16]};
                    end
                    3'd5:
                    begin
                        res.port = ata_seq_pkg::PORT_CMD;
                        res.data = {8'd0, job.flag ? ata_seq_pkg::CMD_WRITE
                                                   : ata_seq_pkg::CMD_READ};
                    end
                    default:
                    begin
                        // closing status read
                        res.action = ata_seq_pkg::ACT_BUS_READ;
                        res.port   = ata_seq_pkg::PORT_CMD;
                        res.last   = 1'b1;
                    end
                endcase
            end
            ata_seq_pkg::JOB_RD_FIRST:
            begin
                res.port = ata_seq_pkg::PORT_DATA;
            end
            ata_seq_pkg::JOB_RD_WORD:
            begin
                if (step_reg == 3'd0)
                begin
                    res.action = ata_seq_pkg::ACT_TO_HOST;
                    res.port   = ata_seq_pkg::PORT_DATA;
                    res.data   = job.arg[15:0];
                    res.last   = 1'b0;
                end
                else
                begin
                    res.port = job.flag ? ata_seq_pkg::PORT_CMD : ata_seq_pkg::PORT_DATA;
                end
            end
            ata_seq_pkg::JOB_WR_WORD:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        res.action = ata_seq_pkg::ACT_BUS_WRITE;
                        res.port   = ata_seq_pkg::PORT_DATA;
                        res.data   = job.arg[15:0];
                        res.last   = !job.flag;
                    end
                    3'd1:
                    begin
                        res.action = ata_seq_pkg::ACT_BUS_WRITE;
                        res.data   = {8'd0, ata_seq_pkg::CMD_FLUSH};
                        res.last   = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ata_seq_pkg::JOB_DONE:
            begin
                res.action = ata_seq_pkg::ACT_DONE;
                res.port   = ata_seq_pkg::PORT_DATA;
                res.ok     = job.flag;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
            step_next      = res.last ? 3'd0 : step_reg + 3'd1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

`ifndef ASSERT_OFF
    a_step_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 3'd0 |-> job_valid)
        else $error("mid-job step with empty queue");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd6)
        else $error("step counter past longest job");

    a_retire_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> step_reg == 3'd0)
        else $error("step not cleared after job retire");

    a_retire_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> out_valid_reg && out_res_reg.last)
        else $error("job retired without last result");
`endif

endmodule
